// ----- rtl/bcfc_pkg.sv -----
package bcfc_pkg;

	localparam int COORD_W  = 32;              // Q16.16 corner coordinate and matrix element
	localparam int CFG_W    = 64;              // one configuration register, two elements
	localparam int MAT_REGS = 8;               // two registers per matrix row
	localparam int IDX_W    = $clog2(MAT_REGS);
	localparam int AXES     = 3;               // x, y, z clip coordinates
	localparam int ROWS     = 4;               // x, y, z and w rows
	localparam int TERMS    = 4;               // three products plus the translation term
	localparam int W_ROW    = 3;
	localparam int FRAC_W   = 16;              // fraction bits of Q16.16
	localparam int PROD_W   = 2 * COORD_W;     // Q32.32 product
	localparam int DOT_W    = PROD_W + 2;      // sum of four Q32.32 terms
	localparam int CMP_W    = DOT_W + 1;       // room for |w| and -|w|

	typedef logic [MAT_REGS-1:0][CFG_W-1:0] mat_t;

	// Clip-space row sums for one corner.
	typedef struct packed {
		logic [AXES-1:0][DOT_W-1:0] clip;
		logic [DOT_W-1:0]           w;
		logic                       last;
	} bcfc_dot_t;

	// Outcode flags for one corner.
	typedef struct packed {
		logic            all_in;   // inside on all three axes
		logic [AXES-1:0] below;
		logic [AXES-1:0] above;
		logic            last;
	} bcfc_flag_t;

	// Matrix element at row r, column c: even column in the low word.
	function automatic logic signed [COORD_W-1:0] mat_elem(input mat_t mat, input logic [1:0] r,
			input logic [1:0] c);
		logic [CFG_W-1:0] word;
		word = mat[{r, c[1]}];
		return c[0] ? $signed(word[CFG_W-1:COORD_W]) : $signed(word[COORD_W-1:0]);
	endfunction

endpackage

// ----- rtl/bcfc_xform.sv -----
module bcfc_xform import bcfc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mat_t                      mat,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] corner_x,
	input  logic signed [COORD_W-1:0] corner_y,
	input  logic signed [COORD_W-1:0] corner_z,
	input  logic                      last_corner,
	output logic                      dot_valid,
	input  logic                      dot_ready,
	output bcfc_dot_t                 dot
);

	logic                              v_s1, v_s2, v_s3;
	logic                              rdy_s1, rdy_s2, rdy_s3;
	logic signed [AXES-1:0][COORD_W-1:0] vec_s1;
	logic                              last_s1, last_s2, last_s3;
	logic signed [PROD_W-1:0]          prod_d  [ROWS][TERMS];
	logic signed [PROD_W-1:0]          prod_s2 [ROWS][TERMS];
	logic signed [DOT_W-1:0]           sum_d   [ROWS];
	logic signed [DOT_W-1:0]           sum_s3  [ROWS];

	// a stage takes new data when it is empty or its contents move on
	assign rdy_s3   = !v_s3 || dot_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// products of one matrix element and one coordinate; w column is the translation
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < AXES; c++) begin
				prod_d[r][c] = mat_elem(mat, 2'(r), 2'(c)) * $signed(vec_s1[c]);
			end
			prod_d[r][AXES] = PROD_W'(mat_elem(mat, 2'(r), 2'(AXES))) <<< FRAC_W;
		end
	end

	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			sum_d[r] = DOT_W'(prod_s2[r][0]) + DOT_W'(prod_s2[r][1])
				+ DOT_W'(prod_s2[r][2]) + DOT_W'(prod_s2[r][3]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			vec_s1  <= {corner_z, corner_y, corner_x};
			last_s1 <= last_corner;
		end
		if (rdy_s2) begin
			prod_s2 <= prod_d;
			last_s2 <= last_s1;
		end
		if (rdy_s3) begin
			sum_s3  <= sum_d;
			last_s3 <= last_s2;
		end
	end

	always_comb begin
		for (int j = 0; j < AXES; j++) begin
			dot.clip[j] = sum_s3[j];
		end
		dot.w    = sum_s3[W_ROW];
		dot.last = last_s3;
	end
	assign dot_valid = v_s3;

endmodule

// ----- rtl/bcfc_classify.sv -----
module bcfc_classify import bcfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       dot_valid,
	output logic       dot_ready,
	input  bcfc_dot_t  dot,
	output logic       flag_valid,
	input  logic       flag_ready,
	output bcfc_flag_t flag
);

	logic                    v_s4, v_s5;
	logic                    rdy_s4, rdy_s5;
	logic signed [CMP_W-1:0] w_ext;
	logic signed [CMP_W-1:0] clip_s4 [AXES];
	logic signed [CMP_W-1:0] mag_s4, nmag_s4;
	logic                    wneg_s4, last_s4;
	logic [AXES-1:0]         in_d, lo_d, hi_d;
	bcfc_flag_t              flag_d, flag_s5;

	assign rdy_s5    = !v_s5 || flag_ready;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign dot_ready = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4) v_s4 <= dot_valid;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	assign w_ext = CMP_W'($signed(dot.w));

	// compare against |w|: the bounds are symmetric, only below/above swap for negative w
	always_comb begin
		for (int j = 0; j < AXES; j++) begin
			in_d[j] = (clip_s4[j] > nmag_s4) && (clip_s4[j] < mag_s4);
			lo_d[j] = clip_s4[j] < nmag_s4;
			hi_d[j] = clip_s4[j] > mag_s4;
		end
		flag_d.all_in = &in_d;
		flag_d.below  = wneg_s4 ? hi_d : lo_d;
		flag_d.above  = wneg_s4 ? lo_d : hi_d;
		flag_d.last   = last_s4;
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			for (int j = 0; j < AXES; j++) begin
				clip_s4[j] <= CMP_W'($signed(dot.clip[j]));
			end
			wneg_s4 <= w_ext[CMP_W-1];
			mag_s4  <= w_ext[CMP_W-1] ? -w_ext : w_ext;
			nmag_s4 <= w_ext[CMP_W-1] ? w_ext : -w_ext;
			last_s4 <= dot.last;
		end
		if (rdy_s5) begin
			flag_s5 <= flag_d;
		end
	end

	assign flag_valid = v_s5;
	assign flag       = flag_s5;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> ((flag_s5.below & flag_s5.above) == '0)
			&& (!flag_s5.all_in || (flag_s5.below == '0 && flag_s5.above == '0)))
		else $error("corner flagged both inside and outside, or below and above");

endmodule

// ----- rtl/bcfc_accum.sv -----
module bcfc_accum import bcfc_pkg::*; #(
	parameter int BOX_CORNERS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       flag_valid,
	output logic       flag_ready,
	input  bcfc_flag_t flag,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       visible
);

	localparam int SEEN_W = $clog2(BOX_CORNERS + 1);
	localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(BOX_CORNERS);

	logic [SEEN_W-1:0] seen_q, seen_d;
	logic              inside_q, inside_d;
	logic [AXES-1:0]   below_q, below_d, above_q, above_d;
	logic              out_valid_q, visible_q;
	logic              adv;

	// only a last corner needs room in the output register
	assign flag_ready = !flag.last || !out_valid_q || out_ready;
	assign adv        = flag_valid && flag_ready;

	always_comb begin
		inside_d = inside_q || flag.all_in;
		seen_d   = seen_q;
		below_d  = below_q;
		above_d  = above_q;
		if (seen_q < SEEN_FULL) begin
			below_d = below_q & flag.below;
			above_d = above_q & flag.above;
			seen_d  = seen_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			inside_q    <= 1'b0;
			below_q     <= '1;
			above_q     <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				if (flag.last) begin
					seen_q   <= '0;
					inside_q <= 1'b0;
					below_q  <= '1;
					above_q  <= '1;
				end else begin
					seen_q   <= seen_d;
					inside_q <= inside_d;
					below_q  <= below_d;
					above_q  <= above_d;
				end
			end
			if (adv && flag.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && flag.last) begin
			visible_q <= !(!inside_d && seen_d >= SEEN_FULL && ((below_d | above_d) != '0));
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = visible_q;

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= SEEN_FULL)
		else $error("corner count ran past the box size");

	a_fresh_box: assert property (@(posedge clk) disable iff (!arst_n)
		(seen_q == '0) |-> (below_q == '1 && above_q == '1 && !inside_q))
		else $error("box state not clear before the first corner");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && flag.last) |=> (seen_q == '0 && out_valid_q))
		else $error("last corner did not close the box");

endmodule

// ----- rtl/box_corner_frustum_cull_top.sv -----
// Channel   Direction  Handshake              Payload
// corner    in         in_valid / in_ready    corner_x, corner_y, corner_z, last_corner
// result    out        out_valid / out_ready  visible (one per box, on its last corner)
// config    in         cfg_we                 cfg_index, cfg_data (matrix rows, 8 x 64 bits)
//
// Throughput is one corner per cycle while out_ready does not hold back a last corner; a corner's
// result, if any, shows on out_valid after the six-register chain input, products, row sums,
// |w| bounds, outcode flags, then the output register.
// Reset clears the matrix to zero and the box state to empty; no clearing pass is needed.
// A result waiting on out_ready stalls only a last corner that reaches the box state;
// earlier corners keep flowing until the pipeline fills.
module box_corner_frustum_cull_top import bcfc_pkg::*; #(
	parameter int BOX_CORNERS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] corner_x,
	input  logic signed [COORD_W-1:0] corner_y,
	input  logic signed [COORD_W-1:0] corner_z,
	input  logic                      last_corner,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      visible
);

	mat_t       mat_q;
	logic       dot_valid, dot_ready;
	bcfc_dot_t  dot;
	logic       flag_valid, flag_ready;
	bcfc_flag_t flag;

	// matrix registers: the user must write them only while no corner is in flight; not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '0;
		end else if (cfg_we) begin
			mat_q[cfg_index] <= cfg_data;
		end
	end

	// transform each corner by the matrix: products, then row sums
	bcfc_xform u_xform (
		.clk        (clk),
		.arst_n     (arst_n),
		.mat        (mat_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.corner_x   (corner_x),
		.corner_y   (corner_y),
		.corner_z   (corner_z),
		.last_corner(last_corner),
		.dot_valid  (dot_valid),
		.dot_ready  (dot_ready),
		.dot        (dot)
	);

	// compare each clip coordinate with +-|w| instead of dividing
	bcfc_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.dot_valid (dot_valid),
		.dot_ready (dot_ready),
		.dot       (dot),
		.flag_valid(flag_valid),
		.flag_ready(flag_ready),
		.flag      (flag)
	);

	// fold outcodes over the box and hold the verdict for transfer
	bcfc_accum #(
		.BOX_CORNERS(BOX_CORNERS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.flag_valid(flag_valid),
		.flag_ready(flag_ready),
		.flag      (flag),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.visible   (visible)
	);

endmodule
